// ===== rtl/tbs_pkg.sv =====
// tbs_pkg: shared constants, codes and field layout of the bilinear texture sampler
// used by bilinear_texture_sampler_unit; depends on nothing
package tbs_pkg;

  localparam int unsigned MaxTexWidth  = 128;
  localparam int unsigned MaxTexHeight = 128;
  localparam int unsigned StoreDepth   = 16384;
  localparam int unsigned AddrW        = $clog2(StoreDepth);
  localparam int unsigned XW           = $clog2(MaxTexWidth);
  localparam int unsigned YW           = $clog2(MaxTexHeight);
  localparam int unsigned SizeW        = 8;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned TexelW       = 3 * ChanW;
  localparam int unsigned FracW        = 16;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned OutW         = 16;
  localparam int unsigned RowW         = ChanW + FracW;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [OutW-1:0] WhiteQ88 = 16'hFF00;

  // s_axis tdata layout, lowest field first
  localparam int unsigned IdxLsb    = 0;
  localparam int unsigned RedLsb    = IdxLsb + AddrW;
  localparam int unsigned GreenLsb  = RedLsb + ChanW;
  localparam int unsigned BlueLsb   = GreenLsb + ChanW;
  localparam int unsigned ULsb      = BlueLsb + ChanW;
  localparam int unsigned VLsb      = ULsb + CoordW;
  localparam int unsigned InBits    = VLsb + CoordW;
  localparam int unsigned InDataW   = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutDataW  = 3 * OutW;

  typedef enum logic [0:0] {
    FuncWrite  = 1'b0,
    FuncSample = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPresent = 2'd0,
    CfgWidth   = 2'd1,
    CfgHeight  = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/tbs_ram.sv =====
// tbs_ram: generic simple dual-port RAM, one write port and two registered read ports
// no package dependency
module tbs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// bilinear_texture_sampler_unit: texel store with wrapped bilinear sampling
// depends on tbs_pkg and tbs_ram (two copies give four texel reads per cycle)
// a sample passes the input, texel coordinate, texel read, row blend and output registers
// throughput: a write or sample per cycle unless stalled, set by the texel ram read ports
// a write retires at the read stage, so a following sample always sees it
// reset clears valid bits and config (no texture, 128 x 128); texel store is not cleared
module bilinear_texture_sampler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // texel_index, red_in, green_in, blue_in, u_coord, v_coord
  input  logic [tbs_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func
  input  logic [0:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // red_out, green_out, blue_out
  output logic [tbs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tbs_pkg::SizeW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW  = tbs_pkg::AddrW;
  localparam int unsigned XW     = tbs_pkg::XW;
  localparam int unsigned YW     = tbs_pkg::YW;
  localparam int unsigned SizeW  = tbs_pkg::SizeW;
  localparam int unsigned ChanW  = tbs_pkg::ChanW;
  localparam int unsigned TexelW = tbs_pkg::TexelW;
  localparam int unsigned FracW  = tbs_pkg::FracW;
  localparam int unsigned OutW   = tbs_pkg::OutW;
  localparam int unsigned RowW   = tbs_pkg::RowW;
  localparam int unsigned ColW   = RowW + FracW + 2;

  // configuration
  logic             present_q;
  logic [SizeW-1:0] tex_width_q;
  logic [SizeW-1:0] tex_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= 1'b0;
      tex_width_q  <= SizeW'(tbs_pkg::MaxTexWidth);
      tex_height_q <= SizeW'(tbs_pkg::MaxTexHeight);
    end else if (cfg_valid_i) begin
      case (tbs_pkg::cfg_idx_e'(cfg_index_i))
        tbs_pkg::CfgPresent: present_q    <= cfg_data_i[0];
        tbs_pkg::CfgWidth:   tex_width_q  <= cfg_data_i;
        tbs_pkg::CfgHeight:  tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SizeW-1:0] w_eff;
  logic [SizeW-1:0] h_eff;

  always_comb begin
    if (tex_width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (tex_width_q > SizeW'(tbs_pkg::MaxTexWidth)) begin
      w_eff = SizeW'(tbs_pkg::MaxTexWidth);
    end else begin
      w_eff = tex_width_q;
    end
    if (tex_height_q == '0) begin
      h_eff = SizeW'(1);
    end else if (tex_height_q > SizeW'(tbs_pkg::MaxTexHeight)) begin
      h_eff = SizeW'(tbs_pkg::MaxTexHeight);
    end else begin
      h_eff = tex_height_q;
    end
  end

  // stage valids and readies
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic s2_is_wr;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign s4_ready  = !s4_valid_q || out_ready;
  assign s3_ready  = !s3_valid_q || s4_ready;
  assign s2_ready  = !s2_valid_q || s2_is_wr || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  assign s_axis_tready_o = s1_ready;

  // stage 1: input register
  tbs_pkg::func_e    s1_func_q;
  logic [AddrW-1:0]  s1_idx_q;
  logic [TexelW-1:0] s1_texel_q;
  logic [FracW-1:0]  s1_fu_q;
  logic [FracW-1:0]  s1_fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid_i) begin
      s1_func_q  <= tbs_pkg::func_e'(s_axis_tuser_i);
      s1_idx_q   <= s_axis_tdata_i[tbs_pkg::IdxLsb +: AddrW];
      s1_texel_q <= {s_axis_tdata_i[tbs_pkg::RedLsb +: ChanW],
                     s_axis_tdata_i[tbs_pkg::GreenLsb +: ChanW],
                     s_axis_tdata_i[tbs_pkg::BlueLsb +: ChanW]};
      s1_fu_q    <= s_axis_tdata_i[tbs_pkg::ULsb +: FracW];
      s1_fv_q    <= s_axis_tdata_i[tbs_pkg::VLsb +: FracW];
    end
  end

  // scale fractions by size-1
  logic [XW-1:0]       wm1;
  logic [YW-1:0]       hm1;
  logic [FracW+XW-1:0] px;
  logic [FracW+YW-1:0] py;
  logic [XW-1:0]       x0, x1;
  logic [YW-1:0]       y0, y1;
  logic [SizeW-1:0]    x0_inc, y0_inc;

  always_comb begin
    wm1    = XW'(w_eff - SizeW'(1));
    hm1    = YW'(h_eff - SizeW'(1));
    px     = (FracW+XW)'(s1_fu_q) * (FracW+XW)'(wm1);
    py     = (FracW+YW)'(s1_fv_q) * (FracW+YW)'(hm1);
    x0     = px[FracW +: XW];
    y0     = py[FracW +: YW];
    x0_inc = SizeW'(x0) + SizeW'(1);
    y0_inc = SizeW'(y0) + SizeW'(1);
    x1     = (x0_inc < w_eff) ? XW'(x0_inc) : '0;
    y1     = (y0_inc < h_eff) ? YW'(y0_inc) : '0;
  end

  // stage 2: texel coordinates
  tbs_pkg::func_e    s2_func_q;
  logic              s2_white_q;
  logic [AddrW-1:0]  s2_idx_q;
  logic [TexelW-1:0] s2_texel_q;
  logic [XW-1:0]     s2_x0_q, s2_x1_q;
  logic [YW-1:0]     s2_y0_q, s2_y1_q;
  logic [FracW-1:0]  s2_wx_q, s2_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_func_q  <= s1_func_q;
      s2_white_q <= !present_q;
      s2_idx_q   <= s1_idx_q;
      s2_texel_q <= s1_texel_q;
      s2_x0_q    <= x0;
      s2_x1_q    <= x1;
      s2_y0_q    <= y0;
      s2_y1_q    <= y1;
      s2_wx_q    <= px[FracW-1:0];
      s2_wy_q    <= py[FracW-1:0];
    end
  end

  assign s2_is_wr = (s2_func_q == tbs_pkg::FuncWrite);

  // row-major addresses, wrapped to the store depth
  logic [YW+SizeW-1:0] row0_base, row1_base;
  logic [AddrW-1:0]    addr00, addr10, addr01, addr11;

  always_comb begin
    row0_base = (YW+SizeW)'(s2_y0_q) * (YW+SizeW)'(w_eff);
    row1_base = (YW+SizeW)'(s2_y1_q) * (YW+SizeW)'(w_eff);
    addr00    = AddrW'(row0_base + (YW+SizeW)'(s2_x0_q));
    addr10    = AddrW'(row0_base + (YW+SizeW)'(s2_x1_q));
    addr01    = AddrW'(row1_base + (YW+SizeW)'(s2_x0_q));
    addr11    = AddrW'(row1_base + (YW+SizeW)'(s2_x1_q));
  end

  logic              ram_we;
  logic [TexelW-1:0] t00, t10, t01, t11;

  assign ram_we = s2_valid_q && s2_is_wr;

  tbs_ram #(
    .Width (TexelW),
    .Depth (tbs_pkg::StoreDepth)
  ) u_ram_row0 (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (s2_idx_q),
    .wdata_i  (s2_texel_q),
    .re_i     (s3_ready),
    .raddr0_i (addr00),
    .raddr1_i (addr10),
    .rdata0_o (t00),
    .rdata1_o (t10)
  );

  tbs_ram #(
    .Width (TexelW),
    .Depth (tbs_pkg::StoreDepth)
  ) u_ram_row1 (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (s2_idx_q),
    .wdata_i  (s2_texel_q),
    .re_i     (s3_ready),
    .raddr0_i (addr01),
    .raddr1_i (addr11),
    .rdata0_o (t01),
    .rdata1_o (t11)
  );

  // stage 3: texels from ram
  logic             s3_white_q;
  logic [FracW-1:0] s3_wx_q, s3_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q && !s2_is_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_white_q <= s2_white_q;
      s3_wx_q    <= s2_wx_q;
      s3_wy_q    <= s2_wy_q;
    end
  end

  // horizontal blend per channel: a*2^16 + (b-a)*wx
  logic [RowW-1:0] row0 [3];
  logic [RowW-1:0] row1 [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [ChanW-1:0]      a0, b0, a1, b1;
      logic signed [ChanW:0] d0, d1;
      logic signed [RowW+1:0] p0, p1;
      a0 = t00[(2-ch)*ChanW +: ChanW];
      b0 = t10[(2-ch)*ChanW +: ChanW];
      a1 = t01[(2-ch)*ChanW +: ChanW];
      b1 = t11[(2-ch)*ChanW +: ChanW];
      d0 = $signed({1'b0, b0}) - $signed({1'b0, a0});
      d1 = $signed({1'b0, b1}) - $signed({1'b0, a1});
      p0 = (RowW+2)'(d0) * (RowW+2)'($signed({1'b0, s3_wx_q}));
      p1 = (RowW+2)'(d1) * (RowW+2)'($signed({1'b0, s3_wx_q}));
      row0[ch] = RowW'($signed({2'b00, a0, {FracW{1'b0}}}) + p0);
      row1[ch] = RowW'($signed({2'b00, a1, {FracW{1'b0}}}) + p1);
    end
  end

  // stage 4: row blends
  logic             s4_white_q;
  logic [FracW-1:0] s4_wy_q;
  logic [RowW-1:0]  s4_row0_q [3];
  logic [RowW-1:0]  s4_row1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      s4_white_q <= s3_white_q;
      s4_wy_q    <= s3_wy_q;
      s4_row0_q  <= row0;
      s4_row1_q  <= row1;
    end
  end

  // vertical blend and round to nearest
  logic [OutW-1:0] chan_out [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [RowW:0]   dr;
      logic signed [ColW-1:0] pc;
      logic signed [ColW-1:0] c;
      dr = $signed({1'b0, s4_row1_q[ch]}) - $signed({1'b0, s4_row0_q[ch]});
      pc = ColW'(dr) * ColW'($signed({1'b0, s4_wy_q}));
      c  = $signed({2'b00, s4_row0_q[ch], {FracW{1'b0}}}) + pc
           + $signed(ColW'(1) <<< (2*FracW - ChanW - 1));
      chan_out[ch] = s4_white_q ? tbs_pkg::WhiteQ88 : c[2*FracW - ChanW +: OutW];
    end
  end

  // output register
  logic [OutW-1:0] out_red_q, out_green_q, out_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s4_valid_q) begin
      out_red_q   <= chan_out[0];
      out_green_q <= chan_out[1];
      out_blue_q  <= chan_out[2];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_blue_q, out_green_q, out_red_q};

  // an empty output register lets the whole pipeline move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled while output register is empty");

  // blended channels never exceed 255.0
  a_result_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_red_q <= tbs_pkg::WhiteQ88) && (out_green_q <= tbs_pkg::WhiteQ88)
                        && (out_blue_q <= tbs_pkg::WhiteQ88))
    else $error("channel result above 255.0");

  // a stalled blend stage keeps its item
  a_s4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && !out_ready |=> s4_valid_q && $stable(s4_wy_q))
    else $error("blend stage lost its item under backpressure");

endmodule
